>>> rtl/ets_pkg.sv
// shared constants and types for the fixed-point exponential series block
`timescale 1ns / 1ps
`default_nettype none

package ets_pkg;

  localparam int MAX_TERMS = 64;
  localparam int FRAC_BITS = 24;

  localparam int ARG_W  = 32;
  localparam int VAL_W  = 48;
  localparam int TOL_W  = VAL_W - 1;
  localparam int CNT_W  = 7;
  localparam int HALF_W = VAL_W / 2;
  localparam int PROD_W = HALF_W + ARG_W;
  localparam int FULL_W = VAL_W + ARG_W;
  localparam int NUM_W  = FULL_W - FRAC_BITS;

  // divider retires one 8-bit quotient digit a cycle
  localparam int DIGIT_W   = 8;
  localparam int DIV_STEPS = (NUM_W + DIGIT_W - 1) / DIGIT_W;
  localparam int DIV_W     = DIV_STEPS * DIGIT_W;
  localparam int STEP_W    = (DIV_STEPS > 1) ? $clog2(DIV_STEPS) : 1;

  typedef logic signed [ARG_W-1:0] arg_t;
  typedef logic signed [VAL_W-1:0] val_t;
  typedef logic [TOL_W-1:0]        tol_t;
  typedef logic [CNT_W-1:0]        cnt_t;
  typedef logic [NUM_W-1:0]        num_t;

  localparam val_t ONE     = val_t'(64'd1 << FRAC_BITS);
  localparam val_t VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam val_t VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
  localparam tol_t TOL_RESET = tol_t'(16777);

  // largest quotient magnitudes that still fit a negative or positive term
  localparam num_t NEG_LIMIT = num_t'(1) << (VAL_W - 1);
  localparam num_t POS_LIMIT = NEG_LIMIT - num_t'(1);

  localparam cnt_t TERM_CAP = cnt_t'(MAX_TERMS);

endpackage

`default_nettype wire

>>> rtl/ets_in_if.sv
// argument channel: valid, ready and the series argument
`timescale 1ns / 1ps
`default_nettype none

interface ets_in_if;
  import ets_pkg::*;

  logic valid;
  logic ready;
  arg_t argument;

  modport source (output valid, output argument, input ready);
  modport sink (input valid, input argument, output ready);
endinterface

`default_nettype wire

>>> rtl/ets_out_if.sv
// result channel: valid, ready, sum and status flags
`timescale 1ns / 1ps
`default_nettype none

interface ets_out_if;
  import ets_pkg::*;

  logic valid;
  logic ready;
  val_t series_sum;
  cnt_t terms_used;
  logic overflow;
  logic cap_reached;

  modport source (output valid, output series_sum, output terms_used,
                  output overflow, output cap_reached, input ready);
  modport sink (input valid, input series_sum, input terms_used,
                input overflow, input cap_reached, output ready);
endinterface

`default_nettype wire

>>> rtl/ets_divider.sv
// iterative unsigned divider, one quotient digit per cycle, small divisor
`timescale 1ns / 1ps
`default_nettype none

module ets_divider (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire ets_pkg::num_t dividend,
  input  wire ets_pkg::cnt_t divisor,
  output ets_pkg::num_t      quotient,
  output logic               done
);
  import ets_pkg::*;

  logic [DIV_W-1:0]  work;
  logic [DIV_W-1:0]  work_next;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W-1:0]  rem_next;
  logic [STEP_W-1:0] count;
  logic              busy;

  // restoring steps for one digit; remainder stays below the divisor
  always_comb begin
    logic [CNT_W:0]   trial;
    logic [CNT_W-1:0] r;
    logic [DIV_W-1:0] w;
    r = rem;
    w = work;
    for (int i = 0; i < DIGIT_W; i++) begin
      trial = {r, w[DIV_W-1]};
      w = {w[DIV_W-2:0], 1'b0};
      if (trial >= {1'b0, divisor}) begin
        r = CNT_W'(trial - {1'b0, divisor});
        w[0] = 1'b1;
      end else begin
        r = trial[CNT_W-1:0];
      end
    end
    rem_next  = r;
    work_next = w;
  end

  assign done     = busy && (count == STEP_W'(DIV_STEPS - 1));
  assign quotient = work[NUM_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (start) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (busy) begin
      busy  <= !done;
      count <= count + STEP_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      work <= DIV_W'(dividend);
      rem  <= '0;
    end else if (busy) begin
      work <= work_next;
      rem  <= rem_next;
    end
  end

endmodule

`default_nettype wire

>>> rtl/exp_taylor_series_top.sv
// top level: exp(x) by a saturating fixed-point taylor series
`timescale 1ns / 1ps
`default_nettype none

// channel   dir  payload                                     transaction when
// arg_ch    in   argument (q8.24)                            valid && ready
// res_ch    out  series_sum (q24.24), terms_used, overflow,  valid && ready
//                cap_reached
// cfg       in   cfg_wr_data -> tolerance (q23.24, unsigned) cfg_wr_en
//
// terms: none when the tolerance is above one, and at most the term cap of 64
// each term: two passes through one 24x32 multiplier, one 80-bit add, the
//   8-bit-a-digit divider, then term clamp and sum update
// reset: synchronous, clears the sequencer and the result valid flag and loads the
//   tolerance reset value
// stalls: one argument at a time; a result waits in S_FINISH while the
//   output register is full, then in it while the next argument is taken

module exp_taylor_series_top (
  input  wire logic          clk,
  input  wire logic          rst,
  ets_in_if.sink             arg_ch,
  ets_out_if.source          res_ch,
  input  wire logic          cfg_wr_en,
  input  wire ets_pkg::tol_t cfg_wr_data
);
  import ets_pkg::*;

  // sequencer codes
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MUL_LO = 3'd1;
  localparam logic [2:0] S_MUL_HI = 3'd2;
  localparam logic [2:0] S_ADD    = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_TERM   = 3'd5;
  localparam logic [2:0] S_SUM    = 3'd6;
  localparam logic [2:0] S_FINISH = 3'd7;

  logic [2:0] state;

  tol_t tolerance;

  // per-argument working state; sum, term and k keep the last item's values
  logic              x_neg;
  logic [ARG_W-1:0]  x_mag;
  val_t              term;
  val_t              sum;
  cnt_t              k;
  logic              ovf;
  logic              cap;

  logic [PROD_W-1:0] plo;
  logic [PROD_W-1:0] phi;

  logic [VAL_W-1:0]  term_mag;
  logic [HALF_W-1:0] mul_a;
  logic [PROD_W-1:0] prod;
  logic [FULL_W-1:0] full;
  num_t              dividend;
  num_t              quotient;
  logic              div_start;
  logic              div_done;

  logic              t_neg;
  logic [VAL_W:0]    sum_wide;
  logic              stop;

  // result register
  logic res_valid;
  val_t res_sum;
  cnt_t res_terms;
  logic res_ovf;
  logic res_cap;
  logic res_load;

  assign arg_ch.ready       = (state == S_IDLE);
  assign res_ch.valid       = res_valid;
  assign res_ch.series_sum  = res_sum;
  assign res_ch.terms_used  = res_terms;
  assign res_ch.overflow    = res_ovf;
  assign res_ch.cap_reached = res_cap;

  // magnitude of the current term, 2^47 included
  assign term_mag = term[VAL_W-1] ? (~term + VAL_W'(1)) : term;

  // shared multiplier: low half of the magnitude first, high half next
  assign mul_a = (state == S_MUL_LO) ? term_mag[HALF_W-1:0] : term_mag[VAL_W-1:HALF_W];
  assign prod  = PROD_W'(mul_a) * PROD_W'(x_mag);

  // floor(|term| * |x| / 2^frac) rebuilt from the two partial products
  assign full     = {phi, {HALF_W{1'b0}}} + FULL_W'(plo);
  assign dividend = full[FRAC_BITS +: NUM_W];

  assign div_start = (state == S_ADD);

  ets_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (dividend),
    .divisor  (k),
    .quotient (quotient),
    .done     (div_done)
  );

  // sign of the new term: old term sign against argument sign
  assign t_neg    = term[VAL_W-1] ^ x_neg;
  assign sum_wide = {sum[VAL_W-1], sum} + {term[VAL_W-1], term};
  assign stop     = term_mag < {1'b0, tolerance};

  assign res_load = (state == S_FINISH) && (!res_valid || res_ch.ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      tolerance <= TOL_RESET;
    end else if (cfg_wr_en) begin
      tolerance <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      sum   <= '0;
      term  <= '0;
      k     <= '0;
      ovf   <= 1'b0;
      cap   <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (arg_ch.valid) begin
            x_neg <= arg_ch.argument[ARG_W-1];
            x_mag <= arg_ch.argument[ARG_W-1] ? (~arg_ch.argument + ARG_W'(1))
                                              : arg_ch.argument;
            sum   <= ONE;
            term  <= ONE;
            k     <= '0;
            ovf   <= 1'b0;
            cap   <= 1'b0;
            // tolerance above one skips the series entirely
            state <= ({1'b0, tolerance} > VAL_W'(ONE)) ? S_FINISH : S_MUL_LO;
          end
        end
        S_MUL_LO: begin
          plo   <= prod;
          k     <= k + cnt_t'(1);
          state <= S_MUL_HI;
        end
        S_MUL_HI: begin
          phi   <= prod;
          state <= S_ADD;
        end
        S_ADD: begin
          state <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_TERM;
          end
        end
        S_TERM: begin
          // clamp the quotient into the signed term range
          if (t_neg) begin
            if (quotient > NEG_LIMIT) begin
              term <= VAL_MIN;
              ovf  <= 1'b1;
            end else begin
              term <= $signed(~quotient[VAL_W-1:0] + VAL_W'(1));
            end
          end else begin
            if (quotient > POS_LIMIT) begin
              term <= VAL_MAX;
              ovf  <= 1'b1;
            end else begin
              term <= $signed(quotient[VAL_W-1:0]);
            end
          end
          state <= S_SUM;
        end
        S_SUM: begin
          if (sum_wide[VAL_W] != sum_wide[VAL_W-1]) begin
            sum <= sum_wide[VAL_W] ? VAL_MIN : VAL_MAX;
            ovf <= 1'b1;
          end else begin
            sum <= $signed(sum_wide[VAL_W-1:0]);
          end
          if (stop) begin
            state <= S_FINISH;
          end else if (k >= TERM_CAP) begin
            cap   <= 1'b1;
            state <= S_FINISH;
          end else begin
            state <= S_MUL_LO;
          end
        end
        S_FINISH: begin
          if (res_load) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (res_load) begin
      res_valid <= 1'b1;
    end else if (res_ch.ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res_sum   <= sum;
      res_terms <= k;
      res_ovf   <= ovf;
      res_cap   <= cap;
    end
  end

endmodule

`default_nettype wire

>>> rtl/ets_checker.sv
// port-level checks on the exponential series top, attached by bind
`timescale 1ns / 1ps
`default_nettype none

module ets_checker (
  input wire logic          clk,
  input wire logic          rst,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          res_valid,
  input wire logic          res_ready,
  input wire ets_pkg::val_t res_sum,
  input wire ets_pkg::cnt_t res_terms,
  input wire logic          res_ovf,
  input wire logic          res_cap
);
  import ets_pkg::*;

  // one argument at a time: ready drops after a transaction
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("argument taken while previous one still in work");

  // a waiting result holds still
  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid && $stable(res_sum) && $stable(res_terms))
    else $error("result changed while stalled");

  a_terms_bound: assert property (@(posedge clk) disable iff (rst)
    res_valid |-> res_terms <= TERM_CAP)
    else $error("terms_used beyond the cap");

  a_cap_count: assert property (@(posedge clk) disable iff (rst)
    res_valid && res_cap |-> res_terms == TERM_CAP)
    else $error("cap flag without the full term count");

  // no terms added means the series was skipped and the result is one
  a_skip_one: assert property (@(posedge clk) disable iff (rst)
    res_valid && (res_terms == '0) |-> (res_sum == ONE) && !res_ovf && !res_cap)
    else $error("skipped series did not give one");

endmodule

bind exp_taylor_series_top ets_checker u_ets_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (arg_ch.valid),
  .in_ready  (arg_ch.ready),
  .res_valid (res_ch.valid),
  .res_ready (res_ch.ready),
  .res_sum   (res_ch.series_sum),
  .res_terms (res_ch.terms_used),
  .res_ovf   (res_ch.overflow),
  .res_cap   (res_ch.cap_reached)
);

`default_nettype wire
